// ===== src/crcse_pkg.sv =====
`timescale 1ns / 1ps
package crcse_pkg;

  // Generator degree limit and derived widths
  localparam int MAX_DEGREE = 32;
  localparam int REM_W      = MAX_DEGREE;
  localparam int DEG_W      = 6;
  localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int POLY_W     = 32;

  // Front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register reset values: generator x^3 + x^2 + 1
  localparam logic [POLY_W-1:0] POLY_RST = POLY_W'(5);
  localparam logic [DEG_W-1:0]  DEG_RST  = DEG_W'(3);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY_TAPS = 2'd0,
    CFG_DEGREE    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic code_bit;
    logic is_check;
    logic word_end;
  } out_item_t;

  // One queued request: the data bit plus, on frame end, the final remainder
  typedef struct packed {
    logic             data_bit;
    logic             frame_end;
    logic [REM_W-1:0] rem;
    logic [DEG_W-1:0] deg;
  } qent_t;

endpackage

// ===== src/crcse_front.sv =====
`timescale 1ns / 1ps
module crcse_front import crcse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POLY_W-1:0]    cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output qent_t                q_ent
);

  logic [POLY_W-1:0] poly_r;
  logic [DEG_W-1:0]  degree_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEG_W-1:0]  deg_eff;
  logic [DEG_W-1:0]  top_pos;
  logic [REM_W-1:0]  mask;
  logic [REM_W-1:0]  rem_m;
  logic [REM_W-1:0]  rem_step;
  logic              fb;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= POLY_RST;
      degree_r <= DEG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLY_TAPS: poly_r   <= cfg_data;
        CFG_DEGREE:    degree_r <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective degree, clamped to 1..MAX_DEGREE
  always_comb begin
    if (degree_r == '0)
      deg_eff = DEG_W'(1);
    else if (degree_r > DEG_W'(MAX_DEGREE))
      deg_eff = DEG_W'(MAX_DEGREE);
    else
      deg_eff = degree_r;
  end

  // One division step
  assign mask     = ~({REM_W{1'b1}} << deg_eff);
  assign rem_m    = rem_r & mask;
  assign top_pos  = deg_eff - DEG_W'(1);
  assign fb       = rem_m[top_pos[IDX_W-1:0]] ^ in_item.data_bit;
  assign rem_step = ((rem_m << 1) & mask) ^ (fb ? (REM_W'(poly_r) & mask) : '0);

  // Request sent to the back end
  always_comb begin
    q_ent.data_bit  = in_item.data_bit;
    q_ent.frame_end = in_item.frame_end;
    q_ent.rem       = rem_step;
    q_ent.deg       = deg_eff;
  end

  assign rem_nxt = q_push ? (in_item.frame_end ? '0 : rem_step) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== src/crcse_fifo.sv =====
`timescale 1ns / 1ps
module crcse_fifo import crcse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  input  logic  pop,
  output qent_t head,
  output logic  empty,
  output logic  full
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== src/crcse_back.sv =====
`timescale 1ns / 1ps
module crcse_back import crcse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  qent_t     q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [DEG_W-1:0] chk_cnt_r, chk_cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DEG_W-1:0] chk_pos;
  logic             load_ok;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Output slot frees when empty or being taken
  assign load_ok = !out_valid_r || !out_stall;
  assign q_pop   = load_ok && (chk_cnt_r == '0) && !q_empty;
  assign chk_pos = chk_cnt_r - DEG_W'(1);

  // Check bits first, then the next queued data bit
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    chk_cnt_nxt   = chk_cnt_r;
    rem_nxt       = rem_r;
    if (load_ok) begin
      if (chk_cnt_r != '0) begin
        out_valid_nxt         = 1'b1;
        out_item_nxt.code_bit = rem_r[chk_pos[IDX_W-1:0]];
        out_item_nxt.is_check = 1'b1;
        out_item_nxt.word_end = (chk_cnt_r == DEG_W'(1));
        chk_cnt_nxt           = chk_pos;
      end else if (!q_empty) begin
        out_valid_nxt         = 1'b1;
        out_item_nxt.code_bit = q_head.data_bit;
        out_item_nxt.is_check = 1'b0;
        out_item_nxt.word_end = 1'b0;
        if (q_head.frame_end) begin
          chk_cnt_nxt = q_head.deg;
          rem_nxt     = q_head.rem;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      chk_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      chk_cnt_r   <= chk_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    rem_r      <= rem_nxt;
  end

endmodule

// ===== src/crc_systematic_encoder.sv =====
// An accepted message bit is written into the queue and then into the output register.
// Throughput: one bit per cycle while the queue is not full; a frame end adds degree check bits
// from the back end, while the 4-entry queue absorbs input and then stalls it;
// a full queue stalls input even while it drains.
// Reset (rst_n low, synchronous): remainder, queue and output clear;
// poly_taps returns to 5 and degree to 3.
`timescale 1ns / 1ps
module crc_systematic_encoder import crcse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POLY_W-1:0]    cfg_data
);

  logic  q_full, q_empty, q_push, q_pop;
  qent_t q_ent, q_head;

  // Front end: accepts bits, runs the division step
  crcse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ent     (q_ent)
  );

  // Request queue
  crcse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end: serializes data and check bits
  crcse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/crcse_checker.sv =====
`timescale 1ns / 1ps
module crcse_checker import crcse_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Reset leaves nothing pending and input open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Word end only on a check bit
  a_end_is_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_item.word_end || out_item.is_check)
    else $error("word end on a message bit");

  // Check bits run back to back until word end
  a_check_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.is_check && !out_item.word_end
      |=> out_valid && out_item.is_check)
    else $error("check bit sequence broken");

endmodule

bind crc_systematic_encoder crcse_checker u_crcse_checker (.*);
